// ===== hw/rtl/omtt_pkg.sv =====
// ----------------------------------------------------------------------------
// omtt_pkg
// Types and constants shared by the offset matched timestamp table.
// ----------------------------------------------------------------------------
package omtt_pkg;

    localparam int OMTT_DEPTH       = 32;
    localparam int OMTT_LIMIT_W     = 6;
    localparam int OMTT_AGE_W       = 6;
    localparam int OMTT_COUNT_W     = 6;
    localparam int OMTT_STAMP_W     = 64;
    localparam int OMTT_OFFSET_W    = 32;
    localparam int OMTT_FLAGS_W     = 32;
    localparam logic [OMTT_LIMIT_W-1:0] OMTT_LIMIT_RESET = 6'd32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_POP    = 2'd1,
        OP_MATCH  = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_op                      operation;
        logic [OMTT_STAMP_W-1:0]  timestamp;
        logic [OMTT_OFFSET_W-1:0] stream_offset;
        logic [OMTT_FLAGS_W-1:0]  entry_flags;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic [OMTT_STAMP_W-1:0]  found_timestamp;
        logic [OMTT_FLAGS_W-1:0]  found_flags;
        logic [OMTT_COUNT_W-1:0]  record_count;
    } t_out;

    typedef struct packed {
        logic [OMTT_STAMP_W-1:0]  stamp;
        logic [OMTT_OFFSET_W-1:0] offset;
        logic [OMTT_FLAGS_W-1:0]  flags;
        logic [OMTT_AGE_W-1:0]    age;
    } t_rec;

endpackage

// ===== hw/rtl/offset_matched_timestamp_table_core.sv =====
// ----------------------------------------------------------------------------
// offset_matched_timestamp_table_core
// Add: the result is registered from S_FINISH, after which the core returns to
// S_IDLE and accepts the next transaction. Pop, match and remove with N held
// records scan the record memory, one read a cycle, then compact it where records
// are taken out, one move a cycle; the result is registered from S_FINISH and the
// next transaction is accepted once the core is back in S_IDLE. A stalled result holds.
// Reset empties the table and sets the stale limit to 32; no clearing pass.
// ----------------------------------------------------------------------------
module offset_matched_timestamp_table_core
    import omtt_pkg::*;
#(
    parameter int TABLE_DEPTH = OMTT_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in                     i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out                    o_out_data,
    input  logic                    i_cfg_we,
    input  logic [OMTT_LIMIT_W-1:0] i_cfg_wdata
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_rec                    r_mem [TABLE_DEPTH];
    t_rec                    r_q;

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [OMTT_STAMP_W-1:0] r_ts, n_ts;
    logic [OMTT_OFFSET_W-1:0] r_off, n_off;
    logic [CW-1:0]           r_held, n_held;
    logic [OMTT_LIMIT_W-1:0] r_limit;
    logic [CW-1:0]           r_idx, n_idx;
    logic                    r_qv, n_qv;
    logic [IW-1:0]           r_qi, n_qi;
    logic [1:0]              r_cnt, n_cnt;
    logic [OMTT_STAMP_W-1:0] r_last_ts, n_last_ts;
    logic [OMTT_FLAGS_W-1:0] r_last_fl, n_last_fl;
    t_out                    r_res, n_res;
    t_out                    r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    logic                    w_accept;
    logic                    w_we;
    logic [IW-1:0]           w_wr_addr;
    t_rec                    w_wr_data;
    logic [IW-1:0]           w_rd_addr;
    logic                    w_hit;
    logic                    w_evict;
    logic [CW-1:0]           w_j;
    logic [1:0]              w_k;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_q <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_limit     <= OMTT_LIMIT_RESET;
            r_qv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_qv        <= n_qv;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_ts      <= n_ts;
        r_off     <= n_off;
        r_idx     <= n_idx;
        r_qi      <= n_qi;
        r_cnt     <= n_cnt;
        r_last_ts <= n_last_ts;
        r_last_fl <= n_last_fl;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_ts        = r_ts;
        n_off       = r_off;
        n_held      = r_held;
        n_idx       = r_idx;
        n_qv        = r_qv;
        n_qi        = r_qi;
        n_cnt       = r_cnt;
        n_last_ts   = r_last_ts;
        n_last_fl   = r_last_fl;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_wr_addr   = r_qi;
        w_wr_data   = r_q;
        w_rd_addr   = r_idx[IW-1:0];
        w_hit       = 1'b0;
        w_evict     = (r_q.age >= r_limit);
        w_j         = CW'(r_qi);
        w_k         = 2'd0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op  = i_in_data.operation;
                    n_ts  = i_in_data.timestamp;
                    n_off = i_in_data.stream_offset;
                    n_idx = '0;
                    n_qv  = 1'b0;
                    n_res = '{status: ST_DONE, found_timestamp: '0,
                              found_flags: '0, record_count: '0};
                    n_state = S_FINISH;
                    case (i_in_data.operation)
                        OP_ADD: begin
                            if (r_held == DEPTH_C) begin
                                n_res.status = ST_FULL;
                            end else begin
                                w_we      = 1'b1;
                                w_wr_addr = r_held[IW-1:0];
                                w_wr_data = '{stamp: i_in_data.timestamp,
                                              offset: i_in_data.stream_offset,
                                              flags: i_in_data.entry_flags,
                                              age: '0};
                                n_held    = r_held + 1'b1;
                            end
                        end
                        OP_POP, OP_MATCH: begin
                            if (r_held == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_held == '0) begin
                                n_res.status = ST_NOTFOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_res.status = ST_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_idx < r_held) begin
                    n_qv  = 1'b1;
                    n_qi  = r_idx[IW-1:0];
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_qv = 1'b0;
                end

                case (r_op)
                    OP_POP:    w_hit = 1'b1;
                    OP_MATCH:  w_hit = (r_q.offset > r_off);
                    OP_REMOVE: w_hit = (r_q.stamp == r_ts);
                    default:   w_hit = 1'b0;
                endcase

                if (r_qv && w_hit) begin
                    n_qv    = 1'b0;
                    n_state = S_SHIFT;
                    case (r_op)
                        OP_POP: begin
                            n_res.found_timestamp = r_q.stamp;
                            n_res.found_flags     = r_q.flags;
                            w_k   = 2'd1;
                            n_idx = w_j + CW'(w_k);
                        end
                        OP_MATCH: begin
                            if (!w_evict) begin
                                w_we      = 1'b1;
                                w_wr_addr = r_qi;
                                w_wr_data = r_q;
                                w_wr_data.age = r_q.age + 1'b1;
                            end
                            if (r_qi != '0) begin
                                n_res.found_timestamp = r_last_ts;
                                n_res.found_flags     = r_last_fl;
                                w_k   = w_evict ? 2'd2 : 2'd1;
                                n_idx = w_j - 1'b1 + CW'(w_k);
                            end else begin
                                n_res.status = ST_EMPTY;
                                w_k   = w_evict ? 2'd1 : 2'd0;
                                n_idx = CW'(w_k);
                            end
                        end
                        OP_REMOVE: begin
                            w_k   = 2'd1;
                            n_idx = w_j + CW'(w_k);
                        end
                        default: begin
                            w_k = 2'd0;
                        end
                    endcase
                    n_cnt = w_k;
                    if (w_k == 2'd0) begin
                        n_state = S_FINISH;
                    end
                end else if (r_qv) begin
                    n_last_ts = r_q.stamp;
                    n_last_fl = r_q.flags;
                end else if (r_idx >= r_held) begin
                    case (r_op)
                        OP_MATCH: begin
                            n_res.found_timestamp = r_last_ts;
                            n_res.found_flags     = r_last_fl;
                            n_cnt   = 2'd1;
                            n_idx   = r_held;
                            n_state = S_SHIFT;
                        end
                        OP_REMOVE: begin
                            n_res.status = ST_NOTFOUND;
                            n_cnt   = 2'd0;
                            n_state = S_FINISH;
                        end
                        default: begin
                            n_cnt   = 2'd0;
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                if (r_idx < r_held) begin
                    n_qv  = 1'b1;
                    n_qi  = r_idx[IW-1:0];
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_qv = 1'b0;
                end
                if (r_qv) begin
                    w_we      = 1'b1;
                    w_wr_addr = IW'(CW'(r_qi) - CW'(r_cnt));
                    w_wr_data = r_q;
                end else if (r_idx >= r_held) begin
                    n_held  = r_held - CW'(r_cnt);
                    n_state = S_FINISH;
                end
            end

            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out              = r_res;
                    n_out.record_count = OMTT_COUNT_W'(r_held);
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= DEPTH_C)
        else $error("record count exceeds table depth");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.operation == OP_ADD && r_held != DEPTH_C)
        |=> r_held == $past(r_held) + 1'b1)
        else $error("add did not grow the table by one record");

    a_scan_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> r_held == $past(r_held))
        else $error("record count changed during a scan");

    a_finish_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !(r_out_valid && i_out_stall))
        |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished transaction was not delivered");

    a_shift_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && n_state == S_FINISH)
        |=> r_held <= $past(r_held))
        else $error("compaction grew the table");

endmodule
